// File: design/slcrc_pkg.sv
// Shared types, constants and the CRC-16/X.25 byte update for the SLIP frame receiver.
`timescale 1ns / 1ps

package slcrc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CrcW    = 16;

  localparam logic [ByteW-1:0] SlipEnd    = 8'hC0;
  localparam logic [ByteW-1:0] SlipEsc    = 8'hDB;
  localparam logic [ByteW-1:0] SlipEscEnd = 8'hDC;
  localparam logic [ByteW-1:0] SlipEscEsc = 8'hDD;

  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly = 16'h8408;
  localparam logic [CrcW-1:0] CrcGood = 16'h0F47;

  // Frames shorter than this cannot hold the two header bytes and the checksum.
  localparam logic [IndexW-1:0] MinFrameLen = 10'd4;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusShort    = 2'd1,
    StatusBadCrc   = 2'd2,
    StatusOverflow = 2'd3
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  out_byte;
    logic [IndexW-1:0] byte_index;
    logic              is_data;
    logic              frame_done;
    status_e           status;
    logic [ByteW-1:0]  dest_id;
    logic [ByteW-1:0]  message_id;
    logic [IndexW-1:0] payload_length;
  } result_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [CrcW-1:0] crc_update(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/slcrc_core.sv
// Decoder core: SLIP unescaping, frame state, running CRC and the end-of-frame verdict.
`timescale 1ns / 1ps

module slcrc_core import slcrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 604
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [ByteW-1:0] byte_i,
  output result_t          res_o
);

  localparam logic [IndexW-1:0] MaxLen = IndexW'(MAX_FRAME);

  logic              esc_q, esc_d;
  logic [IndexW-1:0] len_q, len_d;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [ByteW-1:0]  first_q, first_d;
  logic [ByteW-1:0]  second_q, second_d;
  logic              ovf_q, ovf_d;

  logic              take;
  logic              close;
  logic [ByteW-1:0]  dbyte;

  always_comb begin
    esc_d    = esc_q;
    len_d    = len_q;
    crc_d    = crc_q;
    first_d  = first_q;
    second_d = second_q;
    ovf_d    = ovf_q;
    take     = 1'b0;
    close    = 1'b0;
    dbyte    = byte_i;
    res_o    = '0;

    if (esc_q) begin
      esc_d = 1'b0;
      if (byte_i == SlipEscEnd) begin
        take  = 1'b1;
        dbyte = SlipEnd;
      end else if (byte_i == SlipEscEsc) begin
        take  = 1'b1;
        dbyte = SlipEsc;
      end
    end else if (byte_i == SlipEnd) begin
      close = 1'b1;
    end else if (byte_i == SlipEsc) begin
      esc_d = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (len_q >= MaxLen) begin
        ovf_d = 1'b1;
      end else begin
        if (len_q == '0) begin
          first_d = dbyte;
        end else if (len_q == IndexW'(1)) begin
          second_d = dbyte;
        end
        crc_d            = crc_update(crc_q, dbyte);
        len_d            = len_q + IndexW'(1);
        res_o.valid      = 1'b1;
        res_o.out_byte   = dbyte;
        res_o.byte_index = len_q;
        res_o.is_data    = 1'b1;
      end
    end

    if (close && (len_q != '0)) begin
      res_o.valid      = 1'b1;
      res_o.frame_done = 1'b1;
      res_o.dest_id    = first_q;
      res_o.message_id = second_q;
      if (len_q >= MinFrameLen) begin
        res_o.payload_length = len_q - MinFrameLen;
      end
      if (ovf_q) begin
        res_o.status = StatusOverflow;
      end else if (len_q < MinFrameLen) begin
        res_o.status = StatusShort;
      end else if (~crc_q != CrcGood) begin
        res_o.status = StatusBadCrc;
      end else begin
        res_o.status = StatusOk;
      end
      len_d    = '0;
      crc_d    = CrcInit;
      first_d  = '0;
      second_d = '0;
      ovf_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= 1'b0;
      len_q    <= '0;
      crc_q    <= CrcInit;
      first_q  <= '0;
      second_q <= '0;
      ovf_q    <= 1'b0;
    end else if (adv_i) begin
      esc_q    <= esc_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      first_q  <= first_d;
      second_q <= second_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// File: design/slcrc_out_stage.sv
// Result register that holds one finished result until the downstream side takes it.
`timescale 1ns / 1ps

module slcrc_out_stage import slcrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    stall_i,
  output logic    busy_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The slot is busy only if its result is held back this cycle.
  assign busy_o = valid_q && stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    res_o       = data_q;
    res_o.valid = valid_q;
  end

endmodule

// File: design/slip_crc16_frame_receiver_unit.sv
// Top level of the SLIP frame receiver with CRC-16/X.25 frame check.
// Path: a result moves from the input register into the result register that drives the ports;
// bytes that cause no result leave the input register and write no result.
// Throughput: one byte per cycle while no held result stalls input, set by the byte-wide CRC update in the core.
// Reset: rst_ni is asynchronous and active low; it empties both registers, clears the escape
// flag, frame length, header bytes and overflow flag, and loads the CRC with 0xFFFF.
`timescale 1ns / 1ps

module slip_crc16_frame_receiver_unit import slcrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 604
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   in_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   out_byte_o,
  output logic [IndexW-1:0]  byte_index_o,
  output logic               is_data_o,
  output logic               frame_done_o,
  output logic [StatusW-1:0] status_o,
  output logic [ByteW-1:0]   dest_id_o,
  output logic [ByteW-1:0]   message_id_o,
  output logic [IndexW-1:0]  payload_length_o
);

  // The input register takes each line beat while in_stall_o is low. Its byte is
  // decoded in the following cycle, and the core's state steps forward at
  // the same edge at which any result is written into the result register.
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_take;
  logic             advance;
  logic             out_busy;
  result_t          core_res;
  result_t          out_res;

  // A byte that yields no result may always move on; one that yields a
  // result waits only while the previous result is still being held back.
  assign advance    = in_valid_q && !(core_res.valid && out_busy);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_byte_i;
    end
  end

  slcrc_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (advance),
    .byte_i (in_byte_q),
    .res_o  (core_res)
  );

  slcrc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && core_res.valid),
    .res_i   (core_res),
    .stall_i (out_stall_i),
    .busy_o  (out_busy),
    .res_o   (out_res)
  );

  // Result fields go straight out of the result register.
  assign out_valid_o      = out_res.valid;
  assign out_byte_o       = out_res.out_byte;
  assign byte_index_o     = out_res.byte_index;
  assign is_data_o        = out_res.is_data;
  assign frame_done_o     = out_res.frame_done;
  assign status_o         = out_res.status;
  assign dest_id_o        = out_res.dest_id;
  assign message_id_o     = out_res.message_id;
  assign payload_length_o = out_res.payload_length;

endmodule

// File: design/slcrc_checker.sv
// Port-level checker for the SLIP frame receiver, with its bind to the top level.
`timescale 1ns / 1ps

module slcrc_checker import slcrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 604
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ByteW-1:0]   out_byte_o,
  input logic [IndexW-1:0]  byte_index_o,
  input logic               is_data_o,
  input logic               frame_done_o,
  input logic [StatusW-1:0] status_o,
  input logic [IndexW-1:0]  payload_length_o
);

  localparam logic [IndexW-1:0] MaxLen = IndexW'(MAX_FRAME);

  a_held_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_index_o))
    else $error("held result beat changed");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_data_o != frame_done_o))
    else $error("result beat is neither data nor verdict, or both");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_data_o |-> (byte_index_o < MaxLen) && (status_o == StatusOk)
      && (payload_length_o == '0))
    else $error("data beat carries verdict fields or an index past the buffer");

  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o && (status_o == StatusShort) |-> (payload_length_o == '0))
    else $error("short frame verdict reports a payload length");

endmodule

bind slip_crc16_frame_receiver_unit slcrc_checker #(
  .MAX_FRAME (MAX_FRAME)
) u_slcrc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_byte_o       (out_byte_o),
  .byte_index_o     (byte_index_o),
  .is_data_o        (is_data_o),
  .frame_done_o     (frame_done_o),
  .status_o         (status_o),
  .payload_length_o (payload_length_o)
);
